[design/nq_pkg.sv]
package nq_pkg;

  // Largest board the cell row supports.
  localparam int unsigned MAX_SIZE = 16;
  localparam int unsigned ROW_W    = $clog2(MAX_SIZE);
  localparam int unsigned SIZE_W   = ROW_W + 1;

  typedef logic [MAX_SIZE-1:0] row_mask_t;

  // Rows blocked for one column by the queens to its left.
  typedef struct packed {
    row_mask_t rows;  // same row
    row_mask_t up;    // rising diagonal, moves one row up per column
    row_mask_t down;  // falling diagonal, moves one row down per column
  } masks_t;

  // Per-cell control from the search sequencer.
  typedef struct packed {
    logic             load;   // take masks from the left neighbor
    logic             place;  // store the trial row as this column's queen
    logic [ROW_W-1:0] trial;  // row being tried in the current column
  } cell_ctl_t;

endpackage

[design/nq_cell.sv]
// One board column: the masks blocked by earlier columns and its queen row.
module nq_cell (
  input  logic              clk,
  input  nq_pkg::cell_ctl_t ctl,
  input  nq_pkg::masks_t    masks_in,
  output nq_pkg::masks_t    masks,
  output logic [nq_pkg::ROW_W-1:0] queen_row,
  output nq_pkg::masks_t    masks_out
);

  nq_pkg::row_mask_t bit_sel;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      masks <= masks_in;
    end
    if (ctl.place) begin
      queen_row <= ctl.trial;
    end
  end

  // Masks the right neighbor sees with a queen at the trial row here.
  always_comb begin
    bit_sel        = nq_pkg::row_mask_t'(1) << ctl.trial;
    masks_out.rows = masks.rows | bit_sel;
    masks_out.up   = (masks.up | bit_sel) << 1;
    masks_out.down = (masks.down | bit_sel) >> 1;
  end

endmodule

[design/n_queens_first_solution_search.sv]
// First-solution N-queens search.
//
// Input channel s_*: one word per request, s_tdata[4:0] = board_size.
// Output channel m_*: on success one word per column, column 0 first, with
// found = 1 and that column's queen row; m_tlast marks the final column.
// When no placement exists (size 2 or 3, or a size of 0 or above 16) a
// single word with found = 0, column = 0, queen_row = 0 and m_tlast = 1.
//
// Timing: one request at a time. s_tready is high only while idle. The
// search advances one trial (or one backtrack) per cycle through a row of
// 16 column cells, each holding the rows blocked by the queens to its left
// and its own queen row. A request runs its trials and backtracks, then
// sends its result words; a size of 0 or above 16 is answered without a
// search.
//
// Reset (rst, synchronous) returns to idle with no word pending. The cell
// contents are not cleared: each column is written before it is read.
// A stalled receiver holds m_tdata and m_tlast steady until taken.
module n_queens_first_solution_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] board_size, [7:5] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] found, [4:1] column, [8:5] queen_row, [15:9] zero
  output logic        m_tlast
);

  localparam int unsigned N = nq_pkg::MAX_SIZE;
  localparam int unsigned RW = nq_pkg::ROW_W;
  localparam int unsigned SW = nq_pkg::SIZE_W;

  typedef enum logic [1:0] {IDLE, SEARCH, EMIT} state_t;

  state_t          state;
  logic [SW-1:0]   size;
  logic [SW-1:0]   col;
  logic [SW-1:0]   trial;
  logic [RW-1:0]   emit_col;
  logic            out_found;
  logic [RW-1:0]   out_column;
  logic [RW-1:0]   out_row;

  nq_pkg::cell_ctl_t ctl      [N];
  nq_pkg::masks_t    masks    [N];
  nq_pkg::masks_t    masks_out[N];
  nq_pkg::masks_t    masks_in [N];
  logic [RW-1:0]     queen    [N];

  logic [SW-1:0]     req_size;
  logic              req_ok;
  logic              start;
  logic              place;
  logic              blocked;
  logic [RW-1:0]     col_idx;
  logic [RW-1:0]     prev_idx;
  nq_pkg::masks_t    cur;

  assign s_tready = (state == IDLE);
  assign req_size = s_tdata[SW-1:0];
  assign req_ok   = (req_size != '0) && (req_size <= SW'(N));
  assign start    = s_tvalid && s_tready && req_ok;

  assign col_idx  = col[RW-1:0];
  assign prev_idx = RW'(col - SW'(1));
  assign cur      = masks[col_idx];
  assign blocked  = cur.rows[trial[RW-1:0]] | cur.up[trial[RW-1:0]]
                  | cur.down[trial[RW-1:0]];
  // Safe row in a column still to fill.
  assign place    = (state == SEARCH) && (col < size) && (trial < size) && !blocked;

  // Row of cells; cell 0 starts from an empty board.
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign masks_in[g]  = '0;
        assign ctl[g].load  = start;
      end else begin : g_rest
        assign masks_in[g]  = masks_out[g-1];
        assign ctl[g].load  = place && (col_idx == RW'(g - 1));
      end
      assign ctl[g].place = place && (col_idx == RW'(g));
      assign ctl[g].trial = trial[RW-1:0];

      nq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[g]),
        .masks_in  (masks_in[g]),
        .masks     (masks[g]),
        .queen_row (queen[g]),
        .masks_out (masks_out[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      col      <= '0;
      trial    <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            size  <= req_size;
            col   <= '0;
            trial <= '0;
            if (req_ok) begin
              state <= SEARCH;
            end else begin
              // Nothing to search: answer not found at once.
              out_found  <= 1'b0;
              out_column <= '0;
              out_row    <= '0;
              m_tlast    <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= EMIT;
            end
          end
        end
        SEARCH: begin
          if (col >= size) begin
            out_found  <= 1'b1;
            out_column <= '0;
            out_row    <= queen[0];
            m_tlast    <= (size == SW'(1));
            emit_col   <= '0;
            m_tvalid   <= 1'b1;
            state      <= EMIT;
          end else if (trial >= size) begin
            if (col == '0) begin
              out_found  <= 1'b0;
              out_column <= '0;
              out_row    <= '0;
              m_tlast    <= 1'b1;
              m_tvalid   <= 1'b1;
              state      <= EMIT;
            end else begin
              // Backtrack: move the previous queen on by one row.
              col   <= col - SW'(1);
              trial <= SW'(queen[prev_idx]) + SW'(1);
            end
          end else if (place) begin
            col   <= col + SW'(1);
            trial <= '0;
          end else begin
            trial <= trial + SW'(1);
          end
        end
        EMIT: begin
          if (m_tready) begin
            if (m_tlast) begin
              m_tvalid <= 1'b0;
              state    <= IDLE;
            end else begin
              emit_col   <= emit_col + RW'(1);
              out_column <= emit_col + RW'(1);
              out_row    <= queen[emit_col + RW'(1)];
              m_tlast    <= (SW'(emit_col) + SW'(2) == size);
            end
          end
        end
        default: begin
          state    <= IDLE;
          m_tvalid <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {7'b0, out_row, out_column, out_found};

endmodule

[design/nq_checker.sv]
module nq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // Stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  // One request at a time: no intake while a word is pending.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output pending");

  // Not-found answer is a single all-zero word.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tlast && m_tdata[8:1] == 8'd0)
    else $error("malformed not-found word");

  // Columns of a solution come out in order, back to back.
  a_col_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[0] && m_tdata[4:1] == $past(m_tdata[4:1]) + 4'd1)
    else $error("solution column out of order");

  // After the final word the block is ready for the next request.
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not idle after final word");

endmodule

bind n_queens_first_solution_search nq_checker u_nq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[test/queens_monitor.sv]
module queens_monitor
  import nq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] board_size, [7:5] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] found, [4:1] column, [8:5] queen_row, [15:9] zero
  input  logic        m_tlast,
  output int unsigned mismatches,
  output int unsigned words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] column;
    logic [ROW_W-1:0] queen_row;
    logic             last;
  } placement_word_t;

  placement_word_t placements_due[$];

  initial begin
    mismatches = 0;
    words_due  = 0;
  end

  // Depth-first search: columns left to right, rows ascending.
  function automatic void solve_board(input logic [SIZE_W-1:0] size);
    logic [ROW_W-1:0] rows [MAX_SIZE];
    int unsigned      n, col, trial, c, gap, k, r;
    bit               safe, done, solved;
    placement_word_t  w;
    n      = 32'(size);
    col    = 0;
    trial  = 0;
    solved = 1'b0;
    done   = (n == 0) || (n > MAX_SIZE);
    while (!done) begin
      if (col >= n) begin
        solved = 1'b1;
        done   = 1'b1;
      end else if (trial >= n) begin
        // column exhausted: back up one column
        if (col == 0) begin
          done = 1'b1;
        end else begin
          col--;
          trial = 32'(rows[col]) + 1;
        end
      end else begin
        safe = 1'b1;
        for (c = 0; c < col; c++) begin
          gap = col - c;
          r   = 32'(rows[c]);
          if (r == trial || r + gap == trial || trial + gap == r)
            safe = 1'b0;
        end
        if (safe) begin
          rows[col] = trial[ROW_W-1:0];
          col++;
          trial = 0;
        end else begin
          trial++;
        end
      end
    end
    if (solved) begin
      for (k = 0; k < n; k++) begin
        w.found     = 1'b1;
        w.column    = k[ROW_W-1:0];
        w.queen_row = rows[k];
        w.last      = (k + 1 == n);
        placements_due.push_back(w);
      end
    end else begin
      w.found     = 1'b0;
      w.column    = '0;
      w.queen_row = '0;
      w.last      = 1'b1;
      placements_due.push_back(w);
    end
  endfunction

  always @(posedge clk) begin : watch
    placement_word_t got, want;
    int unsigned     bad;
    bad = 0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.found     = m_tdata[0];
        got.column    = m_tdata[4:1];
        got.queen_row = m_tdata[8:5];
        got.last      = m_tlast;
        if (placements_due.size() == 0) begin
          $error("unexpected word: found %0d column %0d queen_row %0d last %0d",
                 got.found, got.column, got.queen_row, got.last);
          bad++;
        end else begin
          want = placements_due.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            bad++;
          end
          if (got.column !== want.column) begin
            $error("column: expected %0d, actual %0d", want.column, got.column);
            bad++;
          end
          if (got.queen_row !== want.queen_row) begin
            $error("queen_row: expected %0d, actual %0d", want.queen_row, got.queen_row);
            bad++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            bad++;
          end
        end
      end
      if (s_tvalid && s_tready)
        solve_board(s_tdata[SIZE_W-1:0]);
    end
    mismatches <= mismatches + bad;
    words_due  <= placements_due.size();
  end

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nq_pkg::*;

  // The limit leaves plenty of room over the slowest mix this stimulus
  // can produce.
  localparam int unsigned CYCLE_LIMIT     = 20_000_000;
  localparam int unsigned RANDOM_REQUESTS = 80;
  localparam int unsigned QUIET_TAIL      = 20;  // last requests with no idling
  localparam int unsigned DRAIN_CYCLES    = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [4:0] board_size, [7:5] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [0] found, [4:1] column, [8:5] queen_row, [15:9] zero
  logic        m_tlast;

  int unsigned mismatches;
  int unsigned words_due;
  bit          bursts_on = 1'b1;

  // Directed boards: every size that has a solution, the two sizes that
  // have none, size zero, and sizes past the supported maximum.
  int unsigned directed_sizes [20] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10,
                                       11, 12, 13, 14, 15, 16, 0, 17, 31, 24};

  n_queens_first_solution_search i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  queens_monitor i_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung search or a lost word ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // Receiver: random stall bursts while bursts_on, otherwise always ready.
  // One assignment per falling edge at most.
  initial begin : sink
    int unsigned span;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (bursts_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      m_tready <= 1'b1;
      span = $urandom_range(1, 20);
      repeat (span) @(negedge clk);
    end
  end

  // Offer one request word; entered and left at a falling edge. A request
  // that follows at once keeps s_tvalid high with no drop in between.
  task automatic send_request(input logic [SIZE_W-1:0] size);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(8 - SIZE_W){1'b0}}, size};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned           pick;
    int unsigned           sixteens_left;
    logic [SIZE_W-1:0]     size;
    sixteens_left = 1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_sizes[i])
      send_request(directed_sizes[i][SIZE_W-1:0]);

    // Random part: mostly small boards that still backtrack a lot, a few
    // slow large ones, plus the unsolvable and out-of-range sizes.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - QUIET_TAIL)
        bursts_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
        size = SIZE_W'($urandom_range(1, 10));
      else if (pick < 75)
        size = SIZE_W'($urandom_range(11, 13));
      else if (pick < 80)
        size = SIZE_W'($urandom_range(14, 15));
      else if (pick < 82 && sixteens_left > 0) begin
        size = SIZE_W'(16);
        sixteens_left--;
      end else if (pick < 90)
        size = SIZE_W'($urandom_range(0, 3));
      else
        size = SIZE_W'($urandom_range(17, 31));
      send_request(size);
    end
    s_tvalid <= 1'b0;

    while (words_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && words_due == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

[n_queens_first_solution_search.f]
design/nq_pkg.sv
design/nq_cell.sv
design/n_queens_first_solution_search.sv
design/nq_checker.sv
test/queens_monitor.sv
test/testbench.sv
